>>> hw/rtl/bqe_pkg.sv
// Shared types, register codes and rotation-table builder for the billboard quad expander.
// Depends on nothing; every other file imports it.
package bqe_pkg;

  // Fixed-point formats: positions Q16.16, vectors and table terms Q2.14, size Q8.8
  typedef logic signed [31:0] pos_t;
  typedef logic signed [15:0] vec16_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [32:0] dot_t;
  typedef logic signed [49:0] scaled_t;
  typedef logic signed [29:0] offs_t;

  // Input request and result payloads
  typedef struct packed {
    pos_t        pos_x;
    pos_t        pos_y;
    pos_t        pos_z;
    logic [15:0] size;
    logic [7:0]  angle;
  } bqe_in_t;

  typedef struct packed {
    pos_t c0_x;
    pos_t c0_y;
    pos_t c0_z;
    pos_t c1_x;
    pos_t c1_y;
    pos_t c1_z;
    pos_t c2_x;
    pos_t c2_y;
    pos_t c2_z;
    pos_t c3_x;
    pos_t c3_y;
    pos_t c3_z;
  } bqe_out_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RIGHT_X = 3'd0,
    CFG_RIGHT_Y = 3'd1,
    CFG_RIGHT_Z = 3'd2,
    CFG_UP_X    = 3'd3,
    CFG_UP_Y    = 3'd4,
    CFG_UP_Z    = 3'd5
  } bqe_cfg_idx_t;

  localparam vec16_t RIGHT_X_RST = 16'sd16384;
  localparam vec16_t RIGHT_Y_RST = 16'sd0;
  localparam vec16_t RIGHT_Z_RST = 16'sd0;
  localparam vec16_t UP_X_RST    = 16'sd0;
  localparam vec16_t UP_Y_RST    = 16'sd0;
  localparam vec16_t UP_Z_RST    = 16'sd16384;

  // Camera basis, index 0..2 = x..z
  typedef struct packed {
    vec16_t [2:0] right;
    vec16_t [2:0] up;
  } bqe_cam_t;

  // Rotation terms; the second and third terms of a row are equal, so keep one
  typedef struct packed {
    vec16_t r0;
    vec16_t r1;
    vec16_t r3;
  } bqe_rot_t;

  // Table lookup stage -> vector unit
  typedef struct packed {
    logic         valid;
    bqe_rot_t     rot;
    pos_t [2:0]   pos;
    logic [15:0]  size;
  } bqe_lkp_t;

  // Vector unit -> corner stage
  typedef struct packed {
    logic         valid;
    pos_t [2:0]   pos;
    offs_t [2:0]  v1;
    offs_t [2:0]  v2;
  } bqe_vec_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // Round a Q30 value to Q2.14, half up
  function automatic vec16_t rnd_q14(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd32768) >>> 16;
    return t[15:0];
  endfunction

  // Build one table row from a 32-bit phase (full turn = 2^32)
  function automatic bqe_rot_t rot_row(input logic [31:0] phase);
    logic [1:0]  quad;
    logic [63:0] rem;
    logic        fold;
    logic [63:0] arg;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] su;
    logic [63:0] cu;
    logic signed [63:0] sp;
    logic signed [63:0] cp;
    logic signed [63:0] cs;
    logic signed [63:0] ss;
    bqe_rot_t row;
    quad = phase[31:30];
    rem  = {34'd0, phase[29:0]};
    fold = rem > (Q30_ONE >> 1);
    arg  = fold ? (Q30_ONE - rem) : rem;
    x    = (arg * PI_Q30) >> 31;
    x2   = (x * x) >> 30;
    // sine series
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    su = (x * t) >> 30;
    // cosine series
    t  = Q30_ONE - x2 / 64'd90;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd2;
    cu = t;
    // undo the octant fold
    sp = fold ? $signed(cu) : $signed(su);
    cp = fold ? $signed(su) : $signed(cu);
    // undo the quadrant fold
    case (quad)
      2'd0:    begin cs = cp;  ss = sp;  end
      2'd1:    begin cs = -sp; ss = cp;  end
      2'd2:    begin cs = -cp; ss = -sp; end
      default: begin cs = sp;  ss = -cp; end
    endcase
    row.r0 = rnd_q14(-cs - ss);
    row.r1 = rnd_q14(cs - ss);
    row.r3 = rnd_q14(ss + cs);
    return row;
  endfunction

endpackage

>>> hw/rtl/bqe_rot_rom.sv
// Rotation table indexed by the 8-bit angle, with a registered lookup stage.
// Depends on bqe_pkg (row builder, payload and stage types).
module bqe_rot_rom #(
  parameter int ANGLE_STEPS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  bqe_pkg::bqe_in_t  in_req,
  output bqe_pkg::bqe_lkp_t lkp
);
  import bqe_pkg::*;

  localparam int ANGLES = 256;

  bqe_rot_t rom [ANGLES];
  bqe_lkp_t lkp_r;
  bqe_lkp_t lkp_nxt;

  // Fill the table at elaboration; angles wrap modulo the step count
  for (genvar a = 0; a < ANGLES; a++) begin : g_row
    localparam longint unsigned ROW   = a % ANGLE_STEPS;
    localparam longint unsigned PHASE = (ROW << 32) / ANGLE_STEPS;
    assign rom[a] = rot_row(PHASE[31:0]);
  end

  // Look up terms and carry the request along
  always_comb begin
    lkp_nxt.valid = in_take;
    lkp_nxt.rot   = rom[in_req.angle];
    lkp_nxt.pos   = {in_req.pos_z, in_req.pos_y, in_req.pos_x};
    lkp_nxt.size  = in_req.size;
  end

  // Clear the valid bit on reset; advance the payload every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lkp_r.valid <= 1'b0;
    end else begin
      lkp_r.valid <= lkp_nxt.valid;
    end
    lkp_r.rot  <= lkp_nxt.rot;
    lkp_r.pos  <= lkp_nxt.pos;
    lkp_r.size <= lkp_nxt.size;
  end

  assign lkp = lkp_r;

endmodule

>>> hw/rtl/bqe_vec_unit.sv
// Offset vectors v1 and v2: term products, dot sums, size scaling and rounding.
// Depends on bqe_pkg (stage structs and fixed-point types).
module bqe_vec_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  bqe_pkg::bqe_cam_t cam,
  input  bqe_pkg::bqe_lkp_t lkp,
  output bqe_pkg::bqe_vec_t vec
);
  import bqe_pkg::*;

  localparam scaled_t RND_HALF = scaled_t'(1) <<< 19;

  // Stage 1: term products
  logic              s1_valid_r;
  pos_t [2:0]        s1_pos_r;
  logic [15:0]       s1_size_r;
  prod_t             s1_pa_r [3];
  prod_t             s1_pb_r [3];
  prod_t             s1_pc_r [3];
  prod_t             s1_pd_r [3];
  // Stage 2: dot sums
  logic              s2_valid_r;
  pos_t [2:0]        s2_pos_r;
  logic [15:0]       s2_size_r;
  dot_t              s2_a1_r [3];
  dot_t              s2_a2_r [3];
  // Stage 3: scaled by size
  logic              s3_valid_r;
  pos_t [2:0]        s3_pos_r;
  scaled_t           s3_m1_r [3];
  scaled_t           s3_m2_r [3];
  // Stage 4: rounded offsets
  bqe_vec_t          vec_r;
  bqe_vec_t          vec_nxt;

  logic signed [16:0] size_s;

  assign size_s = $signed({1'b0, s2_size_r});

  // Advance valid bits and the rounded offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      vec_r.valid <= 1'b0;
    end else begin
      s1_valid_r  <= lkp.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      vec_r.valid <= vec_nxt.valid;
    end
    vec_r.pos <= vec_nxt.pos;
    vec_r.v1  <= vec_nxt.v1;
    vec_r.v2  <= vec_nxt.v2;
  end

  // Round Q14.36 to Q14.16, half up
  always_comb begin
    vec_nxt.valid = s3_valid_r;
    vec_nxt.pos   = s3_pos_r;
    for (int d = 0; d < 3; d++) begin
      vec_nxt.v1[d] = offs_t'((s3_m1_r[d] + RND_HALF) >>> 20);
      vec_nxt.v2[d] = offs_t'((s3_m2_r[d] + RND_HALF) >>> 20);
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    s1_pos_r  <= lkp.pos;
    s1_size_r <= lkp.size;
    for (int d = 0; d < 3; d++) begin
      s1_pa_r[d] <= prod_t'(lkp.rot.r0) * prod_t'(cam.right[d]);
      s1_pb_r[d] <= prod_t'(lkp.rot.r1) * prod_t'(cam.up[d]);
      s1_pc_r[d] <= prod_t'(lkp.rot.r1) * prod_t'(cam.right[d]);
      s1_pd_r[d] <= prod_t'(lkp.rot.r3) * prod_t'(cam.up[d]);
    end

    s2_pos_r  <= s1_pos_r;
    s2_size_r <= s1_size_r;
    for (int d = 0; d < 3; d++) begin
      s2_a1_r[d] <= dot_t'(s1_pa_r[d]) + dot_t'(s1_pb_r[d]);
      s2_a2_r[d] <= dot_t'(s1_pc_r[d]) + dot_t'(s1_pd_r[d]);
    end

    s3_pos_r <= s2_pos_r;
    for (int d = 0; d < 3; d++) begin
      s3_m1_r[d] <= scaled_t'(size_s) * scaled_t'(s2_a1_r[d]);
      s3_m2_r[d] <= scaled_t'(size_s) * scaled_t'(s2_a2_r[d]);
    end
  end

  assign vec = vec_r;

endmodule

>>> hw/rtl/bqe_corner.sv
// Corner stage: pos +/- v1 and pos +/- v2 with 32-bit saturation, registered output.
// Depends on bqe_pkg (stage struct, result payload).
module bqe_corner (
  input  logic              clk,
  input  logic              rst_n,
  input  bqe_pkg::bqe_vec_t vec,
  output logic              out_valid,
  output bqe_pkg::bqe_out_t out_res
);
  import bqe_pkg::*;

  logic     out_valid_r;
  bqe_out_t out_res_r;
  bqe_out_t out_res_nxt;
  pos_t     c0 [3];
  pos_t     c1 [3];
  pos_t     c2 [3];
  pos_t     c3 [3];

  // Exact sum, then clamp to the 32-bit range
  function automatic pos_t sat_add(input pos_t p, input offs_t v, input logic sub);
    logic signed [33:0] s;
    s = sub ? (34'(p) - 34'(v)) : (34'(p) + 34'(v));
    if (s > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      c0[d] = sat_add(vec.pos[d], vec.v1[d], 1'b0);
      c1[d] = sat_add(vec.pos[d], vec.v2[d], 1'b0);
      c2[d] = sat_add(vec.pos[d], vec.v1[d], 1'b1);
      c3[d] = sat_add(vec.pos[d], vec.v2[d], 1'b1);
    end
    out_res_nxt.c0_x = c0[0];
    out_res_nxt.c0_y = c0[1];
    out_res_nxt.c0_z = c0[2];
    out_res_nxt.c1_x = c1[0];
    out_res_nxt.c1_y = c1[1];
    out_res_nxt.c1_z = c1[2];
    out_res_nxt.c2_x = c2[0];
    out_res_nxt.c2_y = c2[1];
    out_res_nxt.c2_z = c2[2];
    out_res_nxt.c3_x = c3[0];
    out_res_nxt.c3_y = c3[1];
    out_res_nxt.c3_z = c3[2];
  end

  // Strobe for one cycle per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vec.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> hw/rtl/billboard_quad_expander_core.sv
// Rotated billboard quad expander: six-stage pipeline, one request per clock.
// A taken request passes through the lookup, product, sum, scale, round and clamp registers
// in that order, and is then on out_res with out_valid.
// Throughput is one request per cycle; busy stays low and the receiver cannot stall.
// Synchronous active-low reset clears the valid bits and loads the default camera basis.
// Depends on bqe_pkg, bqe_rot_rom, bqe_vec_unit and bqe_corner.
module billboard_quad_expander_core #(
  parameter int ANGLE_STEPS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  bqe_pkg::bqe_in_t                in_req,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bqe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data,
  output logic                            out_valid,
  output bqe_pkg::bqe_out_t               out_res
);
  import bqe_pkg::*;

  bqe_cam_t cam_r;
  bqe_cam_t cam_nxt;
  bqe_lkp_t lkp;
  bqe_vec_t vec;
  logic     in_take;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_take   = start & ~busy;

  // Decode configuration writes
  always_comb begin
    cam_nxt = cam_r;
    if (cfg_valid && cfg_ready) begin
      unique case (bqe_cfg_idx_t'(cfg_index))
        CFG_RIGHT_X: cam_nxt.right[0] = cfg_data;
        CFG_RIGHT_Y: cam_nxt.right[1] = cfg_data;
        CFG_RIGHT_Z: cam_nxt.right[2] = cfg_data;
        CFG_UP_X:    cam_nxt.up[0]    = cfg_data;
        CFG_UP_Y:    cam_nxt.up[1]    = cfg_data;
        CFG_UP_Z:    cam_nxt.up[2]    = cfg_data;
        default:     cam_nxt = cam_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r.right <= {RIGHT_Z_RST, RIGHT_Y_RST, RIGHT_X_RST};
      cam_r.up    <= {UP_Z_RST, UP_Y_RST, UP_X_RST};
    end else begin
      cam_r <= cam_nxt;
    end
  end

  bqe_rot_rom #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_rot_rom (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_req  (in_req),
    .lkp     (lkp)
  );

  bqe_vec_unit u_vec_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cam   (cam_r),
    .lkp   (lkp),
    .vec   (vec)
  );

  bqe_corner u_corner (
    .clk       (clk),
    .rst_n     (rst_n),
    .vec       (vec),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
